>>> hw/rtl/olist_pkg.sv
`default_nettype none

package olist_pkg;

  // list depth, the widths that follow from it, and the value width
  localparam int CAPACITY = 16;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  // request codes
  typedef enum logic [1:0] {
    FN_INS_FRONT = 2'd0,
    FN_INS_BACK  = 2'd1,
    FN_FIND      = 2'd2,
    FN_DELETE    = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // where a cell takes its next value from
  typedef enum logic [1:0] {
    SEL_HOLD = 2'd0,
    SEL_PREV = 2'd1,
    SEL_NEXT = 2'd2,
    SEL_IN   = 2'd3
  } cell_sel_t;

  // per-cell control from the list controller
  typedef struct packed {
    cell_sel_t sel;
    logic      occupied;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/olist_cell.sv
`default_nettype none

module olist_cell (
  input  wire logic                                     clk,
  input  wire olist_pkg::cell_ctl_t                     ctl,
  input  wire logic signed [olist_pkg::VAL_W-1:0]       in_value,
  input  wire logic signed [olist_pkg::VAL_W-1:0]       prev_value,
  input  wire logic signed [olist_pkg::VAL_W-1:0]       next_value,
  output logic signed [olist_pkg::VAL_W-1:0]            value,
  output logic                                          match
);

  logic signed [olist_pkg::VAL_W-1:0] val_r;
  logic signed [olist_pkg::VAL_W-1:0] val_nxt;

  // compare against the request value, only when the slot holds an entry
  assign match = ctl.occupied && (val_r == in_value);
  assign value = val_r;

  // pick the next content of this slot
  always_comb begin
    unique case (ctl.sel)
      olist_pkg::SEL_HOLD: val_nxt = val_r;
      olist_pkg::SEL_PREV: val_nxt = prev_value;
      olist_pkg::SEL_NEXT: val_nxt = next_value;
      olist_pkg::SEL_IN:   val_nxt = in_value;
      default:             val_nxt = val_r;
    endcase
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/ordered_list_insert_find_delete_core.sv
`default_nettype none

// channel   direction  ports                                   handshake
// in        input      in_func, in_value                       in_valid / in_ready
// out       output     out_status, out_found, out_position,    out_valid / out_ready
//                      out_count
//
// one request per cycle: all cells compare in parallel and shift one slot
// toward their neighbor in the same cycle, and the result register is
// loaded on acceptance. reset (synchronous, rst_n low) clears the entry count
// and the result valid; entry contents need no clearing. a held result only
// stalls input when out_ready is low, since in_ready = !out_valid || out_ready.

module ordered_list_insert_find_delete_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [1:0]                            in_func,
  input  wire logic signed [olist_pkg::VAL_W-1:0]    in_value,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [1:0]                                 out_status,
  output logic                                       out_found,
  output logic [olist_pkg::POS_W-1:0]                out_position,
  output logic [olist_pkg::CNT_W-1:0]                out_count
);

  localparam int CAP = olist_pkg::CAPACITY;

  logic                             accept;
  olist_pkg::func_t                 func;
  logic [olist_pkg::CNT_W-1:0]      count_r;
  logic [olist_pkg::CNT_W-1:0]      count_nxt;
  logic                             full;
  logic                             empty;

  logic [CAP-1:0]                   match_v;
  logic [CAP-1:0]                   earlier_v;
  logic [CAP-1:0]                   seen_v;
  logic [CAP-1:0]                   first_v;
  logic [CAP-1:0]                   occ_v;
  logic                             any_match;
  logic [olist_pkg::POS_W-1:0]      match_pos;

  olist_pkg::cell_ctl_t             ctl_v [CAP];
  logic signed [olist_pkg::VAL_W-1:0] cell_val [CAP];

  logic                             out_valid_r;
  olist_pkg::status_t               status_r;
  olist_pkg::status_t               status_nxt;
  logic                             found_r;
  logic                             found_nxt;
  logic [olist_pkg::POS_W-1:0]      pos_r;
  logic [olist_pkg::POS_W-1:0]      pos_nxt;
  logic [olist_pkg::CNT_W-1:0]      cnt_out_r;

  // handshake
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign func      = olist_pkg::func_t'(in_func);
  assign full      = (count_r == olist_pkg::CNT_W'(CAP));
  assign empty     = (count_r == '0);

  // cell row with neighbor links
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic signed [olist_pkg::VAL_W-1:0] prev_v;
    logic signed [olist_pkg::VAL_W-1:0] next_v;

    if (i == 0) begin : g_head
      assign prev_v = in_value;
    end else begin : g_mid_p
      assign prev_v = cell_val[i-1];
    end

    if (i == CAP - 1) begin : g_tail
      assign next_v = cell_val[i];
    end else begin : g_mid_n
      assign next_v = cell_val[i+1];
    end

    assign occ_v[i] = (olist_pkg::CNT_W'(i) < count_r);

    // matches in front of this slot, and at or in front of it
    assign earlier_v[i] = |(match_v & ({CAP{1'b1}} >> (CAP - i)));
    assign seen_v[i]    = earlier_v[i] | match_v[i];
    assign first_v[i]   = match_v[i] & ~earlier_v[i];

    olist_cell u_cell (
      .clk        (clk),
      .ctl        (ctl_v[i]),
      .in_value   (in_value),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cell_val[i]),
      .match      (match_v[i])
    );
  end

  assign any_match = |match_v;

  // position of the first match
  always_comb begin
    match_pos = '0;
    for (int i = 0; i < CAP; i++) begin
      if (first_v[i]) begin
        match_pos = match_pos | olist_pkg::POS_W'(i);
      end
    end
  end

  // per-cell moves for the accepted request
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      ctl_v[i].occupied = occ_v[i];
      ctl_v[i].sel      = olist_pkg::SEL_HOLD;
      if (accept) begin
        unique case (func)
          olist_pkg::FN_INS_FRONT: begin
            if (!full) ctl_v[i].sel = olist_pkg::SEL_PREV;
          end
          olist_pkg::FN_INS_BACK: begin
            if (!full && (olist_pkg::CNT_W'(i) == count_r)) ctl_v[i].sel = olist_pkg::SEL_IN;
          end
          olist_pkg::FN_FIND: begin
            ctl_v[i].sel = olist_pkg::SEL_HOLD;
          end
          olist_pkg::FN_DELETE: begin
            // close the gap: slots from the match up to the last but one
            if (seen_v[i] && (olist_pkg::CNT_W'(i + 1) < count_r)) begin
              ctl_v[i].sel = olist_pkg::SEL_NEXT;
            end
          end
          default: ctl_v[i].sel = olist_pkg::SEL_HOLD;
        endcase
      end
    end
  end

  // result fields and new count
  always_comb begin
    status_nxt = olist_pkg::ST_OK;
    found_nxt  = 1'b0;
    pos_nxt    = '0;
    count_nxt  = count_r;
    unique case (func)
      olist_pkg::FN_INS_FRONT, olist_pkg::FN_INS_BACK: begin
        if (full) status_nxt = olist_pkg::ST_FULL;
        else count_nxt = count_r + olist_pkg::CNT_W'(1);
      end
      olist_pkg::FN_FIND: begin
        if (any_match) begin
          found_nxt = 1'b1;
          pos_nxt   = match_pos;
        end else begin
          status_nxt = olist_pkg::ST_MISSING;
        end
      end
      olist_pkg::FN_DELETE: begin
        if (empty) begin
          status_nxt = olist_pkg::ST_EMPTY;
        end else if (any_match) begin
          found_nxt = 1'b1;
          pos_nxt   = match_pos;
          count_nxt = count_r - olist_pkg::CNT_W'(1);
        end else begin
          status_nxt = olist_pkg::ST_MISSING;
        end
      end
      default: status_nxt = olist_pkg::ST_OK;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) count_r <= count_nxt;
      if (accept) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      found_r   <= found_nxt;
      pos_r     <= pos_nxt;
      cnt_out_r <= count_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_found    = found_r;
  assign out_position = pos_r;
  assign out_count    = cnt_out_r;

endmodule

`default_nettype wire

>>> bench/tb_ordered_list_insert_find_delete_core.sv
`default_nettype none

module tb_ordered_list_insert_find_delete_core;
  timeunit 1ns;
  timeprecision 1ps;

  import olist_pkg::*;

  // one pending request beat
  typedef struct packed {
    func_t              fn;
    logic [VAL_W-1:0]   value;
  } request_t;

  // one expected result beat
  typedef struct packed {
    status_t            status;
    logic               found;
    logic [POS_W-1:0]   position;
    logic [CNT_W-1:0]   count;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_func = FN_INS_FRONT;
  logic signed [VAL_W-1:0]   in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                out_status;
  logic                      out_found;
  logic [POS_W-1:0]          out_position;
  logic [CNT_W-1:0]          out_count;

  request_t                  request_q[$];
  list_result_t              reply_q[$];
  int unsigned               err_cnt = 0;
  int unsigned               idle_pct = 0;
  int unsigned               stall_pct = 0;

  // shadow copy of the list contents, front at index 0
  logic [VAL_W-1:0]          list_vals [CAPACITY];
  int                        held = 0;

  logic [VAL_W-1:0]          value_pool [8];

  ordered_list_insert_find_delete_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_position (out_position),
    .out_count    (out_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one request to the shadow list and return the result it yields
  function automatic list_result_t apply_to_list(func_t fn, logic [VAL_W-1:0] v);
    list_result_t r;
    int           hit;
    r.status   = ST_OK;
    r.found    = 1'b0;
    r.position = '0;
    hit = -1;
    for (int i = 0; i < held; i++) begin
      if (hit < 0 && list_vals[i] == v) hit = i;
    end
    case (fn)
      FN_INS_FRONT: begin
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = held; i > 0; i--) list_vals[i] = list_vals[i-1];
          list_vals[0] = v;
          held++;
        end
      end
      FN_INS_BACK: begin
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_vals[held] = v;
          held++;
        end
      end
      FN_FIND: begin
        if (hit >= 0) begin
          r.found    = 1'b1;
          r.position = hit[POS_W-1:0];
        end else begin
          r.status = ST_MISSING;
        end
      end
      default: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else if (hit >= 0) begin
          r.found    = 1'b1;
          r.position = hit[POS_W-1:0];
          for (int i = hit; i + 1 < held; i++) list_vals[i] = list_vals[i+1];
          held--;
        end else begin
          r.status = ST_MISSING;
        end
      end
    endcase
    r.count = held[CNT_W-1:0];
    return r;
  endfunction

  task automatic queue_request(func_t fn, logic [VAL_W-1:0] v);
    request_t req;
    req.fn    = fn;
    req.value = v;
    request_q.push_back(req);
  endtask

  // growing bursts favor inserts, shrinking bursts favor finds and deletes
  function automatic func_t pick_func(bit grow);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 35) return FN_INS_FRONT;
      if (r < 70) return FN_INS_BACK;
      if (r < 85) return FN_FIND;
      return FN_DELETE;
    end
    if (r < 10) return FN_INS_FRONT;
    if (r < 20) return FN_INS_BACK;
    if (r < 50) return FN_FIND;
    return FN_DELETE;
  endfunction

  // mostly values from a small pool so duplicates and matches are common
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 8) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || reply_q.size() != 0) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : drive
    request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        reply_q.push_back(apply_to_list(func_t'(in_func), in_value));
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          req = request_q.pop_front();
          in_valid <= 1'b1;
          in_func  <= req.fn;
          in_value <= req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result backpressure
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else        out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: result beat with none expected: status %0d found %0d pos %0d count %0d",
                 $time, out_status, out_found, out_position, out_count);
        err_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          err_cnt++;
        end
        if (out_found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, out_found);
          err_cnt++;
        end
        if (out_position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position,
                   out_position);
          err_cnt++;
        end
        if (out_count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, out_count);
          err_cnt++;
        end
      end
    end
  end

  // stimulus sequencing
  initial begin : stim
    int  n;
    int  burst;
    bit  grow;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list, extreme values, duplicates, full list, misses
    queue_request(FN_FIND, 32'h1234_5678);
    queue_request(FN_DELETE, 32'h1234_5678);
    queue_request(FN_INS_BACK, 32'h8000_0000);
    queue_request(FN_INS_FRONT, 32'h7fff_ffff);
    queue_request(FN_INS_BACK, 32'hffff_ffff);
    queue_request(FN_INS_FRONT, 32'h0000_0000);
    for (int i = 0; i < 10; i++) queue_request(FN_INS_BACK, $urandom);
    queue_request(FN_INS_BACK, 32'h7fff_ffff);
    queue_request(FN_INS_BACK, 32'h5555_5555);
    queue_request(FN_INS_FRONT, 32'haaaa_aaaa);
    queue_request(FN_INS_BACK, 32'haaaa_aaaa);
    queue_request(FN_FIND, 32'h5555_5555);
    queue_request(FN_FIND, 32'h1234_5678);
    queue_request(FN_DELETE, 32'h1234_5678);
    queue_request(FN_DELETE, 32'h0000_0000);
    queue_request(FN_DELETE, 32'h7fff_ffff);
    wait_drained();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
      n = 0;
      grow = ($urandom_range(0, 1) == 1);
      while (n < 200) begin
        burst = $urandom_range(12, 40);
        for (int i = 0; i < burst; i++) queue_request(pick_func(grow), pick_value());
        n += burst;
        grow = ~grow;
      end
      // sender holds off until every result is back
      wait_drained();
    end

    repeat (6) @(negedge clk);
    if (err_cnt == 0 && reply_q.size() == 0) begin
      $display("ordered_list_insert_find_delete_core regression: pass");
    end else begin
      $display("ordered_list_insert_find_delete_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("ordered_list_insert_find_delete_core regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
